// ===== hdl/scd_pkg.sv =====
`timescale 1ns / 1ps

package scd_pkg;

  localparam int unsigned ScanW  = 8;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned AsciiW = 7;

  localparam logic [KeyW-1:0]   KeyLShift = 7'h2A;
  localparam logic [KeyW-1:0]   KeyRShift = 7'h36;
  localparam logic [KeyW-1:0]   KeyCaps   = 7'h3A;
  localparam logic [KeyW-1:0]   KeyLimit  = 7'd58;
  localparam logic [AsciiW-1:0] AsciiLowA = 7'h61;
  localparam logic [AsciiW-1:0] AsciiLowZ = 7'h7A;

  // Decode result and next flag state for one scan-code beat.
  typedef struct packed {
    logic              emit;
    logic [AsciiW-1:0] ascii;
    logic              shift_d;
    logic              caps_d;
  } decode_t;

  function automatic logic [AsciiW-1:0] keymap_plain(input logic [IdxW-1:0] idx);
    logic [AsciiW-1:0] ch;
    case (idx)
      6'd1:    ch = 7'h1B;
      6'd2:    ch = 7'h31;
      6'd3:    ch = 7'h32;
      6'd4:    ch = 7'h33;
      6'd5:    ch = 7'h34;
      6'd6:    ch = 7'h35;
      6'd7:    ch = 7'h36;
      6'd8:    ch = 7'h37;
      6'd9:    ch = 7'h38;
      6'd10:   ch = 7'h39;
      6'd11:   ch = 7'h30;
      6'd12:   ch = 7'h2D;
      6'd13:   ch = 7'h3D;
      6'd14:   ch = 7'h08;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h71;
      6'd17:   ch = 7'h77;
      6'd18:   ch = 7'h65;
      6'd19:   ch = 7'h72;
      6'd20:   ch = 7'h74;
      6'd21:   ch = 7'h79;
      6'd22:   ch = 7'h75;
      6'd23:   ch = 7'h69;
      6'd24:   ch = 7'h6F;
      6'd25:   ch = 7'h70;
      6'd26:   ch = 7'h5B;
      6'd27:   ch = 7'h5D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h61;
      6'd31:   ch = 7'h73;
      6'd32:   ch = 7'h64;
      6'd33:   ch = 7'h66;
      6'd34:   ch = 7'h67;
      6'd35:   ch = 7'h68;
      6'd36:   ch = 7'h6A;
      6'd37:   ch = 7'h6B;
      6'd38:   ch = 7'h6C;
      6'd39:   ch = 7'h3B;
      6'd40:   ch = 7'h27;
      6'd41:   ch = 7'h60;
      6'd43:   ch = 7'h5C;
      6'd44:   ch = 7'h7A;
      6'd45:   ch = 7'h78;
      6'd46:   ch = 7'h63;
      6'd47:   ch = 7'h76;
      6'd48:   ch = 7'h62;
      6'd49:   ch = 7'h6E;
      6'd50:   ch = 7'h6D;
      6'd51:   ch = 7'h2C;
      6'd52:   ch = 7'h2E;
      6'd53:   ch = 7'h2F;
      6'd55:   ch = 7'h2A;
      6'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [AsciiW-1:0] keymap_shifted(input logic [IdxW-1:0] idx);
    logic [AsciiW-1:0] ch;
    case (idx)
      6'd1:    ch = 7'h1B;
      6'd2:    ch = 7'h21;
      6'd3:    ch = 7'h40;
      6'd4:    ch = 7'h23;
      6'd5:    ch = 7'h24;
      6'd6:    ch = 7'h25;
      6'd7:    ch = 7'h5E;
      6'd8:    ch = 7'h26;
      6'd9:    ch = 7'h2A;
      6'd10:   ch = 7'h28;
      6'd11:   ch = 7'h29;
      6'd12:   ch = 7'h5F;
      6'd13:   ch = 7'h2B;
      6'd14:   ch = 7'h08;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h51;
      6'd17:   ch = 7'h57;
      6'd18:   ch = 7'h45;
      6'd19:   ch = 7'h52;
      6'd20:   ch = 7'h54;
      6'd21:   ch = 7'h59;
      6'd22:   ch = 7'h55;
      6'd23:   ch = 7'h49;
      6'd24:   ch = 7'h4F;
      6'd25:   ch = 7'h50;
      6'd26:   ch = 7'h7B;
      6'd27:   ch = 7'h7D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h41;
      6'd31:   ch = 7'h53;
      6'd32:   ch = 7'h44;
      6'd33:   ch = 7'h46;
      6'd34:   ch = 7'h47;
      6'd35:   ch = 7'h48;
      6'd36:   ch = 7'h4A;
      6'd37:   ch = 7'h4B;
      6'd38:   ch = 7'h4C;
      6'd39:   ch = 7'h3A;
      6'd40:   ch = 7'h22;
      6'd41:   ch = 7'h7E;
      6'd43:   ch = 7'h7C;
      6'd44:   ch = 7'h5A;
      6'd45:   ch = 7'h58;
      6'd46:   ch = 7'h43;
      6'd47:   ch = 7'h56;
      6'd48:   ch = 7'h42;
      6'd49:   ch = 7'h4E;
      6'd50:   ch = 7'h4D;
      6'd51:   ch = 7'h3C;
      6'd52:   ch = 7'h3E;
      6'd53:   ch = 7'h3F;
      6'd55:   ch = 7'h2A;
      6'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/scancode_to_ascii_decoder_core.sv =====
`timescale 1ns / 1ps

// Set 1 scan-code to ASCII decoder.
// Slave channel: one scan-code byte per beat on s_axis_tdata_i; bit 7 marks
// a key release. Master channel: one beat per key press with a nonzero
// table entry, carrying the ASCII code and the caps lock state at the press.
// Shift make/break, caps lock make, other releases, keys beyond the table
// and table holes update state only and produce no output beat.
// Path: an input beat is captured in the input register and decoded
// into the output register as soon as the output slot is free.
// Throughput: one beat per cycle while the receiver keeps tready high, set
// by the single decode stage between the input and output registers.
// Stall: when the receiver holds tready low, the output register holds its
// beat, the input register holds the next one, and tready to the sender
// drops only when both are full.
// Reset: clears both valid bits, the shift flag and the caps lock flag.
module scancode_to_ascii_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [6:0] ascii_char, [7] caps_on
);

  logic                           in_valid_q;
  logic [scd_pkg::ScanW-1:0]      in_scan_q;
  logic                           out_valid_q;
  logic                           out_valid_d;
  logic [scd_pkg::AsciiW-1:0]     out_ascii_q;
  logic                           out_caps_q;
  logic                           shift_q;
  logic                           caps_q;
  logic                           out_free;
  logic                           advance;
  scd_pkg::decode_t               dec;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Retire the held scan code into the output stage.
  assign advance  = in_valid_q && out_free;

  assign s_axis_tready_o = !in_valid_q || out_free;

  scd_decode u_decode (
    .scan_i  (in_scan_q),
    .shift_i (shift_q),
    .caps_i  (caps_q),
    .dec_o   (dec)
  );

  // Input register: take a new beat whenever the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_scan_q <= s_axis_tdata_i;
    end
  end

  // Keyboard state advances once per retired scan code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (advance) begin
      shift_q <= dec.shift_d;
      caps_q  <= dec.caps_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && dec.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec.emit) begin
      out_ascii_q <= dec.ascii;
      out_caps_q  <= caps_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_caps_q, out_ascii_q};

endmodule

// ===== hdl/scd_decode.sv =====
`timescale 1ns / 1ps

module scd_decode (
  input  logic [scd_pkg::ScanW-1:0] scan_i,
  input  logic                      shift_i,
  input  logic                      caps_i,
  output scd_pkg::decode_t          dec_o
);

  logic                           brk;
  logic [scd_pkg::KeyW-1:0]       key;
  logic                           is_shift;
  logic [scd_pkg::AsciiW-1:0]     plain;
  logic [scd_pkg::AsciiW-1:0]     shifted;
  logic                           is_letter;
  logic                           use_shift;
  logic [scd_pkg::AsciiW-1:0]     ch;

  assign brk      = scan_i[scd_pkg::ScanW-1];
  assign key      = scan_i[scd_pkg::KeyW-1:0];
  assign is_shift = (key == scd_pkg::KeyLShift) || (key == scd_pkg::KeyRShift);

  assign plain     = scd_pkg::keymap_plain(key[scd_pkg::IdxW-1:0]);
  assign shifted   = scd_pkg::keymap_shifted(key[scd_pkg::IdxW-1:0]);
  // Caps lock only affects letters.
  assign is_letter = (plain >= scd_pkg::AsciiLowA) && (plain <= scd_pkg::AsciiLowZ);
  assign use_shift = is_letter ? (caps_i ^ shift_i) : shift_i;
  assign ch        = use_shift ? shifted : plain;

  always_comb begin
    dec_o.emit    = 1'b0;
    dec_o.ascii   = ch;
    dec_o.shift_d = shift_i;
    dec_o.caps_d  = caps_i;
    if (brk) begin
      // A release of either shift drops the single flag.
      if (is_shift) begin
        dec_o.shift_d = 1'b0;
      end
    end else if (is_shift) begin
      dec_o.shift_d = 1'b1;
    end else if (key == scd_pkg::KeyCaps) begin
      dec_o.caps_d = ~caps_i;
    end else if (key < scd_pkg::KeyLimit) begin
      dec_o.emit = (ch != '0);
    end
  end

endmodule
